// ----- rtl/core/triple_root_counter_timer_assert.svh -----
// assertion macros for the counter/timer block
// no dependencies; included by the top level
`ifndef TRIPLE_ROOT_COUNTER_TIMER_ASSERT_SVH
`define TRIPLE_ROOT_COUNTER_TIMER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define TRCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked in every cycle, reset included
`define TRCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRCT_ASSERT(lbl, prop, msg)
`define TRCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/trct_pkg.sv -----
// shared types, codes and helpers for the triple counter/timer
// no dependencies
package trct_pkg;

  localparam int NUM_TMR = 3;
  localparam int MODE_W  = 13;

  // commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // register offsets
  localparam logic [3:0] OFF_COUNT  = 4'd0;
  localparam logic [3:0] OFF_MODE   = 4'd4;
  localparam logic [3:0] OFF_TARGET = 4'd8;

  // mode bit positions
  localparam int B_RESET_TGT = 3;
  localparam int B_IRQ_TGT   = 4;
  localparam int B_IRQ_OVF   = 5;
  localparam int B_REPEAT    = 6;
  localparam int B_TOGGLE    = 7;
  localparam int B_SRC0      = 8;
  localparam int B_SRC1      = 9;
  localparam int B_REQUEST   = 10;
  localparam int B_TGT_FLAG  = 11;
  localparam int B_OVF_FLAG  = 12;
  localparam logic [9:0] MODE_WR_MASK = 10'h3FF;

  // divisor resets and fixed divisor of timer 2
  localparam logic [15:0] DOT_DIV_RST = 16'd5;
  localparam logic [15:0] HB_DIV_RST  = 16'd2146;
  localparam logic [15:0] TMR2_DIV    = 16'd8;

  // configuration register indexes
  localparam logic REG_DOT_DIV = 1'b0;
  localparam logic REG_HB_DIV  = 1'b1;

  // per-timer access, already decoded for that timer
  typedef struct packed {
    logic        tick;
    logic        rd;
    logic        wr;
    logic [3:0]  reg_off;
    logic [15:0] data;
  } op_t;

  typedef struct packed {
    logic [15:0] dot_div;
    logic [15:0] hb_div;
  } div_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              line;
    logic              raised;
  } fire_t;

  // interrupt firing: pulse or toggle, one-shot disarms both enables
  function automatic fire_t fire(input logic [MODE_W-1:0] m_in, input logic line_in);
    fire_t r;
    r.mode   = m_in;
    r.line   = line_in;
    r.raised = 1'b1;
    if (m_in[B_TOGGLE]) begin
      r.line              = ~line_in;
      r.raised            = r.line;
      r.mode[B_REQUEST]   = ~r.line;
    end else begin
      r.mode[B_REQUEST]   = 1'b1;
    end
    if (!r.mode[B_REPEAT]) begin
      r.mode[B_IRQ_TGT] = 1'b0;
      r.mode[B_IRQ_OVF] = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/trct_apb.sv -----
// configuration registers: dotclock and hblank divisors behind an apb port
// depends on trct_pkg
module trct_apb (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output trct_pkg::div_t    divs
);
  import trct_pkg::*;

  logic [15:0] dot_div;
  logic [15:0] hb_div;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_div <= DOT_DIV_RST;
      hb_div  <= HB_DIV_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_DOT_DIV) dot_div <= pwdata[15:0];
      if (paddr[2] == REG_HB_DIV)  hb_div  <= pwdata[15:0];
    end
  end

  // read back
  assign prdata = (paddr[2] == REG_HB_DIV) ? {16'd0, hb_div} : {16'd0, dot_div};

  assign divs.dot_div = dot_div;
  assign divs.hb_div  = hb_div;
endmodule

// ----- rtl/core/trct_timer.sv -----
// one 16-bit counter/timer: state registers and per-item next-state logic
// depends on trct_pkg
module trct_timer (
  input  logic           clk,
  input  logic           rst,
  input  trct_pkg::op_t  op,
  input  logic [15:0]    divisor,
  input  logic           use_bit9,
  output logic [15:0]    rd_val,
  output logic           irq
);
  import trct_pkg::*;

  logic [15:0]       cnt, cnt_next;
  logic [MODE_W-1:0] mode, mode_next;
  logic [15:0]       tgt, tgt_next;
  logic              line, line_next;
  logic [15:0]       rem, rem_next;

  logic              div_on;
  logic [15:0]       div_eff;
  logic [16:0]       rem_inc;
  logic              div_done;
  logic              go;
  logic [15:0]       cnt_inc;
  logic [MODE_W-1:0] m;
  logic              l;
  logic [15:0]       c;
  fire_t             f;

  // divided clock source and its remainder
  assign div_on   = use_bit9 ? mode[B_SRC1] : mode[B_SRC0];
  assign div_eff  = (divisor == 16'd0) ? 16'd1 : divisor;
  assign rem_inc  = {1'b0, rem} + 17'd1;
  assign div_done = rem_inc >= {1'b0, div_eff};
  assign go       = !div_on || div_done;
  assign cnt_inc  = cnt + 16'd1;

  // next state and result for the current item
  always_comb begin
    cnt_next  = cnt;
    mode_next = mode;
    tgt_next  = tgt;
    line_next = line;
    rem_next  = rem;
    irq       = 1'b0;
    rd_val    = 16'd0;
    m         = mode;
    l         = line;
    c         = cnt_inc;
    f         = '0;
    if (op.tick) begin
      if (div_on) rem_next = div_done ? 16'd0 : rem_inc[15:0];
      if (go) begin
        // target hit is handled before overflow
        if (cnt_inc == tgt) begin
          m[B_TGT_FLAG] = 1'b1;
          if (m[B_IRQ_TGT]) begin
            f   = fire(m, l);
            m   = f.mode;
            l   = f.line;
            irq = f.raised;
          end
          if (m[B_RESET_TGT]) c = 16'd0;
        end
        if (cnt == 16'hFFFF) begin
          m[B_OVF_FLAG] = 1'b1;
          if (m[B_IRQ_OVF]) begin
            f   = fire(m, l);
            m   = f.mode;
            l   = f.line;
            irq = irq | f.raised;
          end
        end
        cnt_next  = c;
        mode_next = m;
        line_next = l;
      end
    end else if (op.rd) begin
      case (op.reg_off)
        OFF_COUNT:  rd_val = cnt;
        OFF_MODE: begin
          rd_val                   = {3'd0, mode};
          mode_next[B_TGT_FLAG]    = 1'b0;
          mode_next[B_OVF_FLAG]    = 1'b0;
        end
        OFF_TARGET: rd_val = tgt;
        default:    rd_val = 16'd0;
      endcase
    end else if (op.wr) begin
      case (op.reg_off)
        OFF_COUNT: cnt_next = op.data;
        OFF_MODE: begin
          mode_next            = {3'd0, op.data[9:0] & MODE_WR_MASK};
          mode_next[B_REQUEST] = 1'b1;
          cnt_next             = 16'd0;
          line_next            = 1'b0;
          rem_next             = 16'd0;
        end
        OFF_TARGET: tgt_next = op.data;
        default:    ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 16'd0;
      mode <= '0;
      tgt  <= 16'd0;
      line <= 1'b0;
      rem  <= 16'd0;
    end else begin
      cnt  <= cnt_next;
      mode <= mode_next;
      tgt  <= tgt_next;
      line <= line_next;
      rem  <= rem_next;
    end
  end
endmodule

// ----- rtl/core/triple_root_counter_timer.sv -----
// three 16-bit counter/timers with a stream command port and apb divisors
// an item passes the input register, then the result register, which is fed by
// one level of timer logic
// throughput: one item per cycle while m_tready does not stall the result,
// set by the timer update
// reset (rst, synchronous): clears timer state and both stages, divisors 5, 2146
module triple_root_counter_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // command[1:0], timer_index[3:2],
                                 // register_offset[7:4], write_data[23:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_data[15:0], irq_raised[18:16], zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import trct_pkg::*;

  div_t        divs;
  logic        in_valid;
  logic [1:0]  in_cmd;
  logic [1:0]  in_idx;
  logic [3:0]  in_off;
  logic [15:0] in_data;
  logic        adv;
  logic        out_valid;
  logic [15:0] out_rd;
  logic [2:0]  out_irq;
  op_t         ops [NUM_TMR];
  logic [15:0] rd_vals [NUM_TMR];
  logic [2:0]  irqs;
  logic [15:0] rd_all;

  trct_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .divs    (divs)
  );

  // stage handshake
  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tdata[1:0];
      in_idx  <= s_tdata[3:2];
      in_off  <= s_tdata[7:4];
      in_data <= s_tdata[23:8];
    end
  end

  // per-timer access decode
  always_comb begin
    for (int t = 0; t < NUM_TMR; t++) begin
      ops[t].tick    = adv && (in_cmd == CMD_TICK);
      ops[t].rd      = adv && (in_cmd == CMD_READ) && (in_idx == 2'(t));
      ops[t].wr      = adv && (in_cmd == CMD_WRITE) && (in_idx == 2'(t));
      ops[t].reg_off = in_off;
      ops[t].data    = in_data;
    end
  end

  trct_timer u_tmr0 (
    .clk (clk), .rst (rst), .op (ops[0]), .divisor (divs.dot_div),
    .use_bit9 (1'b0), .rd_val (rd_vals[0]), .irq (irqs[0])
  );

  trct_timer u_tmr1 (
    .clk (clk), .rst (rst), .op (ops[1]), .divisor (divs.hb_div),
    .use_bit9 (1'b0), .rd_val (rd_vals[1]), .irq (irqs[1])
  );

  trct_timer u_tmr2 (
    .clk (clk), .rst (rst), .op (ops[2]), .divisor (TMR2_DIV),
    .use_bit9 (1'b1), .rd_val (rd_vals[2]), .irq (irqs[2])
  );

  // unselected timers return zero, so the read data is a plain or
  assign rd_all = rd_vals[0] | rd_vals[1] | rd_vals[2];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rd  <= rd_all;
      out_irq <= irqs;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_irq, out_rd};

  // checks
  `include "triple_root_counter_timer_assert.svh"

  `TRCT_ASSERT(a_irq_only_on_tick,
    adv && (in_cmd != CMD_TICK) |=> m_tdata[18:16] == 3'd0, "irq on a non-tick item")
  `TRCT_ASSERT(a_rd_only_on_read,
    adv && (in_cmd != CMD_READ) |=> m_tdata[15:0] == 16'd0, "read data on a non-read item")
  `TRCT_ASSERT(a_one_read_source,
    $countones({rd_vals[0] != 16'd0, rd_vals[1] != 16'd0, rd_vals[2] != 16'd0}) <= 1,
    "more than one timer drives read data")
  `TRCT_ASSERT_ALWAYS(a_reset_empty,
    rst |=> !m_tvalid && s_tready, "stages not empty after reset")
endmodule
